>>> hw/rtl/static_linked_list_engine_core_assert.svh
// Assertion macros used by the linked list engine RTL.
// Each macro expects the clock aclk and the active-low reset aresetn in scope.
`ifndef STATIC_LINKED_LIST_ENGINE_CORE_ASSERT_SVH
`define STATIC_LINKED_LIST_ENGINE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLL_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SLL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/sll_pkg.sv
// Types, constants and helper functions of the linked list engine.
// No dependencies; used by the top level.
package sll_pkg;

    localparam int NODES     = 32;
    localparam int IDX_W     = $clog2(NODES);
    localparam int POS_W     = 5;
    localparam int COUNT_W   = 5;
    localparam int VALUE_W   = 32;
    localparam int COUNT_MAX = NODES - 2;

    typedef logic [IDX_W-1:0] idx_t;

    localparam idx_t FREE_HEAD = '0;
    localparam idx_t LIST_HEAD = idx_t'(NODES - 1);

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic                      op;
        logic [POS_W-1:0]          position;
        logic signed [VALUE_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]                status;
        logic [IDX_W-1:0]          slot;
        logic signed [VALUE_W-1:0] removed_value;
        logic [COUNT_W-1:0]        list_length;
    } out_item_t;

    // Link of a node that has not been written since reset: node i points to
    // i+1, except for the last two nodes, whose links end their chains.
    function automatic idx_t link_reset(input idx_t idx);
        idx_t res;
        if (idx < idx_t'(NODES - 2)) begin
            res = idx + idx_t'(1);
        end else begin
            res = '0;
        end
        return res;
    endfunction

endpackage

>>> hw/rtl/sll_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sll_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/static_linked_list_engine_core.sv
// An insert runs S_CHECK, S_POP, S_WALK, S_LINK1, S_LINK2 and S_DONE, a delete
// S_CHECK, S_WALK, S_DEL1, S_DEL2 and S_DONE, and an out-of-range or full request
// S_CHECK and S_DONE; the walk length follows the position. One item at a time; the
// pointer walk reads one link per cycle through the link RAM's single read port.
// The next item is taken while the result waits in the output register. Reset (aresetn,
// synchronous, active low) empties the list and rebuilds the free chain via valid bits.
module static_linked_list_engine_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  sll_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output sll_pkg::out_item_t m_data
);
    import sll_pkg::*;

    // One state per access step of the sequencer. Every access to a given node
    // within one item is ordered by these states, so the RAM never sees a read
    // and a write of the same entry that could disagree.
    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_POP,
        S_WALK,
        S_LINK1,
        S_LINK2,
        S_DEL1,
        S_DEL2,
        S_DONE
    } state_t;

    state_t                    state_reg;
    in_item_t                  req_reg;
    idx_t                      free_head_reg;
    logic [COUNT_W-1:0]        count_reg;
    logic [POS_W-1:0]          steps_reg;
    idx_t                      cur_reg;
    idx_t                      j_reg;
    idx_t                      k_reg;
    idx_t                      lk_reg;
    logic [1:0]                res_status_reg;
    idx_t                      res_slot_reg;
    logic signed [VALUE_W-1:0] res_removed_reg;
    logic [NODES-1:0]          valid_reg;
    idx_t                      rd_addr_reg;
    logic                      rd_valid_reg;
    logic                      m_valid_reg;
    out_item_t                 m_data_reg;

    // Read and write controls of the two memories.
    idx_t                 rd_addr;
    logic                 link_we;
    idx_t                 link_waddr;
    idx_t                 link_wdata;
    idx_t                 link_q;
    idx_t                 link_rd;
    logic                 val_we;
    logic [VALUE_W-1:0]   val_q;
    logic                 ins_range_err;
    logic                 del_range_err;
    logic                 out_free;

    // The free chain head (link of node 0) lives in a register, so node 0 is
    // never written to the link RAM.
    sll_ram #(
        .WIDTH (IDX_W),
        .DEPTH (NODES)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (rd_addr),
        .rdata (link_q)
    );

    sll_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (NODES)
    ) u_value_ram (
        .aclk  (aclk),
        .we    (val_we),
        .waddr (free_head_reg),
        .wdata (req_reg.value),
        .raddr (rd_addr),
        .rdata (val_q)
    );

    // A node not written since reset reads as its reset link.
    assign link_rd = rd_valid_reg ? link_q : link_reset(rd_addr_reg);

    // Position checks. Widen by one bit so that count plus one cannot wrap.
    assign ins_range_err = (req_reg.position == '0) ||
        ({1'b0, req_reg.position} > ({1'b0, count_reg} + (COUNT_W+1)'(1)));
    assign del_range_err = (req_reg.position == '0) ||
        (req_reg.position > count_reg);

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        rd_addr    = LIST_HEAD;
        link_we    = 1'b0;
        link_waddr = j_reg;
        link_wdata = lk_reg;
        val_we     = 1'b0;
        case (state_reg)
            S_CHECK: begin
                if (req_reg.op == OP_INSERT) begin
                    // Fetch the link of the node being popped off the free chain,
                    // and store the new value into that node right away.
                    rd_addr = free_head_reg;
                    val_we  = !ins_range_err && (free_head_reg != FREE_HEAD);
                end
            end
            S_WALK: begin
                // Follow the link just read; this also fetches the link and the
                // value of the node after the predecessor on the last step.
                rd_addr = link_rd;
            end
            S_LINK1: begin
                link_we    = 1'b1;
                link_waddr = j_reg;
                link_wdata = lk_reg;
            end
            S_LINK2: begin
                link_we    = 1'b1;
                link_waddr = k_reg;
                link_wdata = j_reg;
            end
            S_DEL1: begin
                link_we    = 1'b1;
                link_waddr = k_reg;
                link_wdata = link_rd;
            end
            S_DEL2: begin
                link_we    = 1'b1;
                link_waddr = j_reg;
                link_wdata = free_head_reg;
            end
            default: begin
                rd_addr = LIST_HEAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        rd_addr_reg  <= rd_addr;
        rd_valid_reg <= valid_reg[rd_addr];
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            free_head_reg <= link_reset(FREE_HEAD);
            count_reg     <= '0;
            valid_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (link_we) begin
                valid_reg[link_waddr] <= 1'b1;
            end
            // In S_DONE a handed-over result is replaced by the next one below.
            if (m_valid_reg && m_ready && (state_reg != S_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        req_reg   <= s_data;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    res_removed_reg <= '0;
                    steps_reg       <= req_reg.position - POS_W'(1);
                    cur_reg         <= LIST_HEAD;
                    if (req_reg.op == OP_INSERT) begin
                        if (ins_range_err) begin
                            res_status_reg <= ST_RANGE;
                            res_slot_reg   <= '0;
                            state_reg      <= S_DONE;
                        end else if (free_head_reg == FREE_HEAD) begin
                            res_status_reg <= ST_FULL;
                            res_slot_reg   <= '0;
                            state_reg      <= S_DONE;
                        end else begin
                            j_reg          <= free_head_reg;
                            res_status_reg <= ST_OK;
                            res_slot_reg   <= free_head_reg;
                            state_reg      <= S_POP;
                        end
                    end else begin
                        res_slot_reg <= '0;
                        if (del_range_err) begin
                            res_status_reg <= ST_RANGE;
                            state_reg      <= S_DONE;
                        end else begin
                            res_status_reg <= ST_OK;
                            state_reg      <= S_WALK;
                        end
                    end
                end
                S_POP: begin
                    free_head_reg <= link_rd;
                    state_reg     <= S_WALK;
                end
                S_WALK: begin
                    if (steps_reg == '0) begin
                        k_reg <= cur_reg;
                        if (req_reg.op == OP_INSERT) begin
                            lk_reg    <= link_rd;
                            state_reg <= S_LINK1;
                        end else begin
                            j_reg        <= link_rd;
                            res_slot_reg <= link_rd;
                            state_reg    <= S_DEL1;
                        end
                    end else begin
                        cur_reg   <= link_rd;
                        steps_reg <= steps_reg - POS_W'(1);
                    end
                end
                S_LINK1: begin
                    state_reg <= S_LINK2;
                end
                S_LINK2: begin
                    count_reg <= count_reg + COUNT_W'(1);
                    state_reg <= S_DONE;
                end
                S_DEL1: begin
                    res_removed_reg <= val_q;
                    state_reg       <= S_DEL2;
                end
                S_DEL2: begin
                    free_head_reg <= j_reg;
                    count_reg     <= count_reg - COUNT_W'(1);
                    state_reg     <= S_DONE;
                end
                S_DONE: begin
                    // Hold the result until the output register is free.
                    if (out_free) begin
                        m_data_reg.status        <= res_status_reg;
                        m_data_reg.slot          <= res_slot_reg;
                        m_data_reg.removed_value <= res_removed_reg;
                        m_data_reg.list_length   <= count_reg;
                        m_valid_reg              <= 1'b1;
                        state_reg                <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `include "static_linked_list_engine_core_assert.svh"

    // Between items the free chain is empty exactly when the list holds every usable node.
    `SLL_ASSERT_SAME(a_free_empty_iff_full, state_reg == S_IDLE, (free_head_reg == FREE_HEAD) == (count_reg == COUNT_W'(COUNT_MAX)), "free chain head disagrees with element count")
    // A successful operation names a real element node, never a chain head.
    `SLL_ASSERT_SAME(a_ok_slot_real, m_valid && (m_data.status == ST_OK), (m_data.slot != FREE_HEAD) && (m_data.slot != LIST_HEAD), "ok result names a head node")
    // A failed operation reports no slot and no removed value.
    `SLL_ASSERT_SAME(a_err_zero, m_valid && (m_data.status != ST_OK), (m_data.slot == '0) && (m_data.removed_value == '0), "error result carries data")
    // A walk never runs past the last element of the list.
    `SLL_ASSERT_NEXT(a_walk_bound, (state_reg == S_CHECK) && (req_reg.op == OP_DELETE) && !del_range_err, steps_reg < count_reg, "walk longer than the list")

endmodule
